// File: rtl/orcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orcc_pkg
// Shared types and constants of the oriented rectangle collision checker.
// ----------------------------------------------------------------------------
package orcc_pkg;

	localparam int MAX_OBSTACLES_DEF = 64;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int CFG_IDX_W         = 3;

	localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd3;

	localparam logic MODE_ADD   = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic        [30:0] obst_width;
		logic        [30:0] obst_height;
		logic        [15:0] obst_angle;
		logic        [30:0] margin;
	} item_t;

	typedef struct packed {
		logic       reply_kind;
		logic [5:0] slot_index;
		logic       table_full;
		logic       collision_free;
		logic       in_bounds;
	} result_t;

	typedef struct packed {
		item_t item;
		logic  in_bounds;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} queue_head_t;

endpackage

// File: rtl/oriented_rect_collision_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_rect_collision_checker
// Table of rotated rectangular obstacles with point collision queries.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  item    | item_valid / stall     | orcc_pkg::item_t
//  result  | result_valid / stall   | orcc_pkg::result_t
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  An add computes sine and cosine, each in eight steps of the sequenced
//  multiplier. A query makes one memory read per stored obstacle through
//  the scan stages s1, s2 and s3. Reset clears the count and the queue and
//  sets the world box to 0 to 10.0 on both axes; memory is not cleared.
//  A two-entry queue lets items enter while the back end or result waits.
// ----------------------------------------------------------------------------
module oriented_rect_collision_checker #(
	parameter int MAX_OBSTACLES = orcc_pkg::MAX_OBSTACLES_DEF,
	parameter int FRAC_BITS     = orcc_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  orcc_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output orcc_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [orcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	orcc_pkg::queue_head_t head;
	logic                  pop;

	orcc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head       (head),
		.pop        (pop)
	);

	orcc_back #(.MAX_OBSTACLES(MAX_OBSTACLES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: rtl/orcc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orcc_front
// Accepts items, holds the world box, classifies queries against it and
// queues jobs for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module orcc_front #(
	parameter int FRAC_BITS = orcc_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  orcc_pkg::item_t                item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [orcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output orcc_pkg::queue_head_t          head,
	input  logic                           pop
);

	localparam logic signed [31:0] BOX_HIGH = 32'(10 << FRAC_BITS);

	logic signed [31:0] x_low_q, x_high_q, y_low_q, y_high_q;
	orcc_pkg::job_t     slot_q [2];
	logic               rd_ptr_q, wr_ptr_q;
	logic [1:0]         fill_q;
	logic               push;
	orcc_pkg::job_t     job_in;

	assign cfg_ready  = 1'b1;
	assign item_stall = (fill_q == 2'd2);
	assign push       = item_valid && !item_stall;

	always_comb begin
		job_in.item      = item;
		job_in.in_bounds = (item.pos_x >= x_low_q) && (item.pos_x <= x_high_q) &&
			(item.pos_y >= y_low_q) && (item.pos_y <= y_high_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= '0;
			x_high_q <= BOX_HIGH;
			y_low_q  <= '0;
			y_high_q <= BOX_HIGH;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				orcc_pkg::REG_X_LOW:  x_low_q  <= cfg_data;
				orcc_pkg::REG_X_HIGH: x_high_q <= cfg_data;
				orcc_pkg::REG_Y_LOW:  y_low_q  <= cfg_data;
				orcc_pkg::REG_Y_HIGH: y_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= job_in;
		end
	end

	always_comb begin
		head.valid = (fill_q != 2'd0);
		head.job   = slot_q[rd_ptr_q];
	end

endmodule

// File: rtl/orcc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orcc_back
// Carries out jobs: stores obstacles with their sine and cosine, or scans
// the obstacle memory for a query, and holds the result register.
// ----------------------------------------------------------------------------
module orcc_back #(
	parameter int MAX_OBSTACLES = orcc_pkg::MAX_OBSTACLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  orcc_pkg::queue_head_t head,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output orcc_pkg::result_t     result
);

	localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int CW = $clog2(MAX_OBSTACLES + 1);

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic        [30:0] w;
		logic        [30:0] h;
		logic signed [17:0] cs;
		logic signed [17:0] sn;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_Z1, ST_Z2, ST_Z3, ST_Z5, ST_T1, ST_T2, ST_T3, ST_FIN,
		ST_WRITE, ST_SCAN, ST_DONE
	} state_t;

	state_t             state_q;
	orcc_pkg::job_t     job_q;
	logic [CW-1:0]      count_q, issue_q;
	logic [15:0]        neg_q;
	logic               phase_q;
	logic [1:0]         quad_q;
	logic [16:0]        z1_q, z2_q, z3_q, z5_q;
	logic [36:0]        acc_q;
	logic signed [17:0] sin_q, cos_q;
	logic               hit_q;
	logic [5:0]         slot_q;
	logic               full_q;
	orcc_pkg::result_t  res_q;
	logic               res_valid_q;

	entry_t             mem [MAX_OBSTACLES];
	entry_t             ent_s1;
	logic               v_s1, v_s2, v_s3;
	logic signed [32:0] dx_s2, dy_s2;
	logic signed [17:0] cs_s2, sn_s2;
	logic        [32:0] limx_s2, limy_s2;
	logic signed [50:0] pcx_s3, psy_s3, psx_s3, pcy_s3;
	logic        [32:0] limx_s3, limy_s3;

	logic [15:0]        ang;
	logic [14:0]        zf;
	logic [20:0]        s_raw;
	logic [17:0]        s_clip;
	logic signed [51:0] l_v, k_v;
	logic        [52:0] l2, k2;
	logic               inside_v;
	logic               issue;
	logic [AW+5:0]      slot_ext;

	assign pop          = (state_q == ST_IDLE) && head.valid;
	assign issue        = (state_q == ST_SCAN) && (issue_q < count_q);
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign slot_ext     = (AW + 6)'(count_q);

	always_comb begin
		ang    = phase_q ? (neg_q + 16'd16384) : neg_q;
		zf     = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
		s_raw  = acc_q[36:16];
		s_clip = (s_raw > 21'd65536) ? 18'd65536 : s_raw[17:0];
		l_v    = 52'(pcx_s3) - 52'(psy_s3);
		k_v    = 52'(psx_s3) + 52'(pcy_s3);
		l2     = {(l_v < 0) ? 52'(-l_v) : 52'(l_v), 1'b0};
		k2     = {(k_v < 0) ? 52'(-k_v) : 52'(k_v), 1'b0};
		inside_v = (l2 < {4'd0, limx_s3, 16'd0}) && (k2 < {4'd0, limy_s3, 16'd0});
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			mem[count_q[AW-1:0]] <= '{cx: job_q.item.pos_x, cy: job_q.item.pos_y,
				w: job_q.item.obst_width, h: job_q.item.obst_height,
				cs: cos_q, sn: sin_q};
		end
		if (issue) begin
			ent_s1 <= mem[issue_q[AW-1:0]];
		end
		dx_s2   <= 33'(job_q.item.pos_x) - 33'(ent_s1.cx);
		dy_s2   <= 33'(job_q.item.pos_y) - 33'(ent_s1.cy);
		cs_s2   <= ent_s1.cs;
		sn_s2   <= ent_s1.sn;
		limx_s2 <= 33'(ent_s1.w) + 33'({job_q.item.margin, 1'b0});
		limy_s2 <= 33'(ent_s1.h) + 33'({job_q.item.margin, 1'b0});
		pcx_s3  <= 51'(cs_s2) * 51'(dx_s2);
		psy_s3  <= 51'(sn_s2) * 51'(dy_s2);
		psx_s3  <= 51'(sn_s2) * 51'(dx_s2);
		pcy_s3  <= 51'(cs_s2) * 51'(dy_s2);
		limx_s3 <= limx_s2;
		limy_s3 <= limy_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= '0;
			count_q     <= '0;
			issue_q     <= '0;
			neg_q       <= '0;
			quad_q      <= '0;
			z1_q        <= '0;
			z2_q        <= '0;
			z3_q        <= '0;
			z5_q        <= '0;
			acc_q       <= '0;
			sin_q       <= '0;
			cos_q       <= '0;
			slot_q      <= '0;
			full_q      <= 1'b0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			hit_q       <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (state_q == ST_IDLE) begin
				hit_q <= 1'b0;
			end else if (v_s3 && inside_v) begin
				hit_q <= 1'b1;
			end
			if ((state_q == ST_DONE) && (!res_valid_q || !result_stall)) begin
				res_valid_q <= 1'b1;
				res_q <= '{reply_kind: job_q.item.mode, slot_index: slot_q,
					table_full: full_q,
					collision_free: (job_q.item.mode == orcc_pkg::MODE_QUERY) && !hit_q,
					in_bounds: (job_q.item.mode == orcc_pkg::MODE_QUERY) &&
						job_q.in_bounds};
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						job_q   <= head.job;
						neg_q   <= 16'd0 - head.job.item.obst_angle;
						phase_q <= 1'b0;
						issue_q <= '0;
						slot_q  <= '0;
						priority if (head.job.item.mode == orcc_pkg::MODE_QUERY) begin
							full_q  <= 1'b0;
							state_q <= ST_SCAN;
						end else if (count_q >= CW'(MAX_OBSTACLES)) begin
							full_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							full_q  <= 1'b0;
							state_q <= ST_Z1;
						end
					end
				end
				ST_Z1: begin
					quad_q  <= ang[15:14];
					z1_q    <= {zf, 2'b00};
					state_q <= ST_Z2;
				end
				ST_Z2: begin
					z2_q    <= 17'((35'(z1_q) * 35'(z1_q) + 35'd32768) >> 16);
					state_q <= ST_Z3;
				end
				ST_Z3: begin
					z3_q    <= 17'((35'(z2_q) * 35'(z1_q) + 35'd32768) >> 16);
					state_q <= ST_Z5;
				end
				ST_Z5: begin
					z5_q    <= 17'((35'(z3_q) * 35'(z2_q) + 35'd32768) >> 16);
					state_q <= ST_T1;
				end
				ST_T1: begin
					acc_q   <= 37'(z1_q) * 37'd102944 + 37'd32768;
					state_q <= ST_T2;
				end
				ST_T2: begin
					acc_q   <= acc_q + 37'(z5_q) * 37'd4640;
					state_q <= ST_T3;
				end
				ST_T3: begin
					acc_q   <= acc_q - 37'(z3_q) * 37'd42048;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!phase_q) begin
						sin_q   <= quad_q[1] ? -$signed(s_clip) : $signed(s_clip);
						phase_q <= 1'b1;
						state_q <= ST_Z1;
					end else begin
						cos_q   <= quad_q[1] ? -$signed(s_clip) : $signed(s_clip);
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					slot_q  <= slot_ext[5:0];
					count_q <= count_q + CW'(1);
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (issue) begin
						issue_q <= issue_q + CW'(1);
					end else if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || !result_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
